### rtl/ght_pkg.sv
// Shared types and constants for the generational handle table.
package ght_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_CHECK  = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BAD   = 2'd2,
    ST_STALE = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_VALUE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_ENABLED = 1'b1;

  // Input transaction payload
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [5:0]       handle_index;
    logic [15:0]      handle_version;
    logic [31:0]      item_value;
  } cmd_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [5:0]        out_index;
    logic [15:0]       out_version;
    logic [31:0]       data_value;
    logic              data_found;
    logic              handle_ok;
  } reply_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // latch the input transaction
    logic rd_slot;   // read slot stores at handle index (or alloc slot)
    logic rd_last;   // read dense stores at the handle's dense position (last position for remove)
    logic commit;    // perform state update and build the result
  } ght_ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic dummy;
  } ght_stat_t;

endpackage

### rtl/ght_if.sv
// Valid/ready channel interface carrying one payload.
interface ght_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/ght_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ght_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/ght_ctrl.sv
// Command sequencer: accept, read slot, read last entry, commit, deliver.
module ght_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ght_pkg::ght_ctrl_t ctrl
);
  import ght_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SLOT, S_LAST, S_COMMIT, S_OUT} state_t;
  state_t state;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    ctrl = '0;
    ctrl.capture = (state == S_IDLE) && in_valid;
    ctrl.rd_slot = (state == S_SLOT);
    ctrl.rd_last = (state == S_LAST);
    ctrl.commit  = (state == S_COMMIT);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_SLOT;
        S_SLOT:   state <= S_LAST;
        S_LAST:   state <= S_COMMIT;
        S_COMMIT: state <= S_OUT;
        S_OUT:    if (out_ready) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_then_out: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> out_valid) else $error("commit not followed by result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule

### rtl/ght_dp.sv
// Datapath: slot and dense stores, counters, and result formation.
module ght_dp #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned VERSION_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ght_pkg::ght_ctrl_t           ctrl,
  input  logic [ght_pkg::CMD_W-1:0]    in_cmd,
  input  logic [$clog2(SLOTS)-1:0]     in_index,
  input  logic [VERSION_WIDTH-1:0]     in_version,
  input  logic [DATA_WIDTH-1:0]        in_value,
  input  logic                         cfg_we,
  input  logic [ght_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ght_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [ght_pkg::STAT_W-1:0]   res_status,
  output logic [$clog2(SLOTS)-1:0]     res_index,
  output logic [VERSION_WIDTH-1:0]     res_version,
  output logic [DATA_WIDTH-1:0]        res_value,
  output logic                         res_found,
  output logic                         res_ok
);
  import ght_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  // Latched transaction
  logic [CMD_W-1:0]         cmd;
  logic [IW-1:0]            hidx;
  logic [VERSION_WIDTH-1:0] hver;
  logic [DATA_WIDTH-1:0]    item;

  // Control state
  logic [SLOTS-1:0] occupied;
  logic [CW-1:0]    live_count, high_water, free_count;
  logic [IW-1:0]    free_head;
  logic [DATA_WIDTH-1:0] fb_value;
  logic             fb_en;

  // Memory ports
  logic                     gen_we, pos_we, nxt_we, own_we, pay_we;
  logic [IW-1:0]            gen_wa, pos_wa, nxt_wa, own_wa, pay_wa;
  logic [VERSION_WIDTH-1:0] gen_wd, gen_rd;
  logic [IW-1:0]            pos_wd, pos_rd, nxt_wd, nxt_rd, own_wd, own_rd;
  logic [DATA_WIDTH-1:0]    pay_wd, pay_rd;
  logic [IW-1:0]            slot_ra, dense_ra;

  // Registered slot reads and derived slot selects
  logic [VERSION_WIDTH-1:0] slot_gen;
  logic [IW-1:0]            slot_pos, slot_nxt;
  logic                     from_free, fresh;
  logic [IW-1:0]            sel_slot, cap_slot;
  logic [IW-1:0]            last_pos;

  assign last_pos  = IW'(live_count - CW'(1));
  assign from_free = (free_count != '0);
  assign fresh     = !from_free && (high_water < SLOTS_C);
  assign sel_slot  = (cmd == CMD_ADD) ? (from_free ? free_head : IW'(high_water)) : hidx;
  assign cap_slot  = (in_cmd == CMD_ADD) ? (from_free ? free_head : IW'(high_water)) :
                     in_index;

  // Read addresses: slot stores at the accepting edge, dense stores in S_SLOT
  assign slot_ra  = ctrl.capture ? cap_slot : sel_slot;
  assign dense_ra = (cmd == CMD_REMOVE) ? last_pos : pos_rd;

  ght_ram #(.WIDTH(VERSION_WIDTH), .DEPTH(SLOTS)) u_gen (.clk, .we(gen_we), .waddr(gen_wa),
    .wdata(gen_wd), .raddr(slot_ra), .rdata(gen_rd));
  ght_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_pos (.clk, .we(pos_we), .waddr(pos_wa),
    .wdata(pos_wd), .raddr(slot_ra), .rdata(pos_rd));
  ght_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_nxt (.clk, .we(nxt_we), .waddr(nxt_wa),
    .wdata(nxt_wd), .raddr(slot_ra), .rdata(nxt_rd));
  ght_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_own (.clk, .we(own_we), .waddr(own_wa),
    .wdata(own_wd), .raddr(dense_ra), .rdata(own_rd));
  ght_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_pay (.clk, .we(pay_we), .waddr(pay_wa),
    .wdata(pay_wd), .raddr(dense_ra), .rdata(pay_rd));

  // Latched transaction, slot read data and dense read data
  logic [DATA_WIDTH-1:0] last_pay;
  logic [IW-1:0]         last_own;
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd  <= in_cmd;
      hidx <= in_index;
      hver <= in_version;
      item <= in_value;
    end
    if (ctrl.rd_slot) begin
      slot_gen <= gen_rd;
      slot_pos <= pos_rd;
      slot_nxt <= nxt_rd;
    end
    if (ctrl.rd_last) begin
      last_pay <= pay_rd;
      last_own <= own_rd;
    end
  end

  // Handle check (valid once slot data is latched)
  logic [STAT_W-1:0] chk;
  always_comb begin
    if ((CW'(hidx) >= high_water) || !occupied[hidx]) chk = ST_BAD;
    else if (slot_gen != hver) chk = ST_STALE;
    else chk = ST_OK;
  end

  logic full;
  assign full = (!from_free && !fresh) || (live_count >= SLOTS_C);
  logic [VERSION_WIDTH-1:0] add_ver;
  assign add_ver = from_free ? slot_gen : '0;
  logic rm_go;
  assign rm_go = (chk == ST_OK) && (live_count != '0);

  // Memory writes at commit
  always_comb begin
    gen_we = 1'b0; gen_wa = sel_slot; gen_wd = '0;
    pos_we = 1'b0; pos_wa = sel_slot; pos_wd = last_pos;
    nxt_we = 1'b0; nxt_wa = hidx;     nxt_wd = free_head;
    own_we = 1'b0; own_wa = last_pos; own_wd = sel_slot;
    pay_we = 1'b0; pay_wa = last_pos; pay_wd = item;
    if (ctrl.commit) begin
      unique case (cmd)
        CMD_ADD: if (!full) begin
          gen_we = fresh;
          pos_we = 1'b1; pos_wd = IW'(live_count);
          own_we = 1'b1; own_wa = IW'(live_count);
          pay_we = 1'b1; pay_wa = IW'(live_count);
        end
        CMD_REMOVE: if (rm_go) begin
          gen_we = 1'b1; gen_wa = hidx; gen_wd = slot_gen + VERSION_WIDTH'(1);
          nxt_we = 1'b1;
          if (slot_pos != last_pos) begin
            pay_we = 1'b1; pay_wa = slot_pos; pay_wd = last_pay;
            own_we = 1'b1; own_wa = slot_pos; own_wd = last_own;
            pos_we = 1'b1; pos_wa = last_own; pos_wd = slot_pos;
          end
        end
        default: ;
      endcase
    end
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied   <= '0;
      live_count <= '0;
      high_water <= '0;
      free_count <= '0;
      free_head  <= '0;
      fb_value   <= '0;
      fb_en      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FALLBACK_VALUE:   fb_value <= DATA_WIDTH'(cfg_data);
          CFG_FALLBACK_ENABLED: fb_en    <= cfg_data[0];
          default: ;
        endcase
      end
      if (ctrl.commit) begin
        unique case (cmd)
          CMD_ADD: if (!full) begin
            if (from_free) begin
              free_head  <= slot_nxt;
              free_count <= free_count - CW'(1);
            end else begin
              high_water <= high_water + CW'(1);
            end
            occupied[sel_slot] <= 1'b1;
            live_count <= live_count + CW'(1);
          end
          CMD_REMOVE: if (rm_go) begin
            occupied[hidx] <= 1'b0;
            free_head  <= hidx;
            free_count <= free_count + CW'(1);
            live_count <= live_count - CW'(1);
          end
          CMD_CLEAR: begin
            occupied   <= '0;
            live_count <= '0;
            high_water <= '0;
            free_count <= '0;
            free_head  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result formation
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      res_status  <= ST_OK;
      res_index   <= '0;
      res_version <= '0;
      res_value   <= '0;
      res_found   <= 1'b0;
      res_ok      <= 1'b0;
      unique case (cmd)
        CMD_ADD: begin
          if (full) begin
            res_status <= ST_FULL;
          end else begin
            res_index   <= sel_slot;
            res_version <= add_ver;
            res_ok      <= 1'b1;
          end
        end
        CMD_LOOKUP: begin
          res_status <= chk;
          if (chk == ST_OK) begin
            res_ok    <= 1'b1;
            res_value <= last_pay;
            res_found <= 1'b1;
          end else if (fb_en) begin
            res_value <= fb_value;
            res_found <= 1'b1;
          end
        end
        CMD_CHECK: begin
          res_status <= chk;
          res_ok     <= (chk == ST_OK);
        end
        CMD_REMOVE: begin
          res_status <= chk;
          res_ok     <= rm_go;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= high_water) else $error("live count above high water");
  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    high_water <= SLOTS_C) else $error("high water beyond table");
  a_free_sum: assert property (@(posedge clk) disable iff (rst)
    (CW'(free_count + live_count) == high_water))
    else $error("free and live slots do not add up");
`endif
endmodule

### rtl/generational_handle_table_core.sv
// Top level of the generational handle table.
// A command is accepted only while the block is idle. The slot stores (generation, dense
// position, free-list link) are read at the accepting edge, the dense stores (payload and
// owner at the handle's dense position, or at the last position for remove) in S_SLOT
// once the dense position is out, their data is latched at the end of S_LAST, and S_COMMIT
// commits the writes and loads the result register, so the result is offered in S_OUT
// and then waits in its register until taken. The next command is accepted in the cycle
// after the result is taken, so a new command is not taken while one is in progress. The
// stores are RAMs with one write port and one registered read port, and the dependent
// reads set the length of this sequence. There is no clearing pass: clear resets only
// counters, the free-list head and occupancy bits.
module generational_handle_table_core #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned VERSION_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  ght_if.sink   in_ch,
  ght_if.source out_ch,
  input  logic                           cfg_we,
  input  logic [ght_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ght_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ght_pkg::*;

  ght_ctrl_t ctrl;

  ght_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .ctrl
  );

  ght_dp #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH), .VERSION_WIDTH(VERSION_WIDTH)) u_dp (
    .clk, .rst, .ctrl,
    .in_cmd(in_ch.data.cmd),
    .in_index(in_ch.data.handle_index),
    .in_version(in_ch.data.handle_version),
    .in_value(in_ch.data.item_value),
    .cfg_we, .cfg_index, .cfg_data,
    .res_status(out_ch.data.status),
    .res_index(out_ch.data.out_index),
    .res_version(out_ch.data.out_version),
    .res_value(out_ch.data.data_value),
    .res_found(out_ch.data.data_found),
    .res_ok(out_ch.data.handle_ok)
  );
endmodule
